/* src/scsi_pkg.sv */
// scsi_pkg: shared types and constants of the s-curve step interpolator
// no dependencies
package scsi_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_STOP = 2'd2,
    OP_HOME = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_JERK_UP   = 3'd0,
    PH_ACCEL     = 3'd1,
    PH_JERK_DOWN = 3'd2,
    PH_CRUISE    = 3'd3,
    PH_DJERK_UP  = 3'd4,
    PH_DECEL     = 3'd5,
    PH_TAIL      = 3'd6,
    PH_SPARE     = 3'd7
  } phase_e;

  localparam logic [2:0] REG_AXIS_COUNT = 3'd0;
  localparam logic [2:0] REG_JERK       = 3'd1;
  localparam logic [2:0] REG_MIN_X      = 3'd2;
  localparam logic [2:0] REG_MAX_X      = 3'd3;
  localparam logic [2:0] REG_MIN_Y      = 3'd4;
  localparam logic [2:0] REG_MAX_Y      = 3'd5;
  localparam logic [2:0] REG_MIN_Z      = 3'd6;
  localparam logic [2:0] REG_MAX_Z      = 3'd7;

  typedef struct packed {
    logic       valid;
    logic [1:0] lead;
    logic [2:0] backward;
    logic [2:0] used;
  } plan_t;

endpackage

/* src/scsi_planner.sv */
// scsi_planner: clamps move targets, computes per-axis deltas and picks the lead axis
// depends on scsi_pkg
module scsi_planner
  import scsi_pkg::*;
(
  input  logic [1:0]         axis_count_i,
  input  logic [2:0][31:0]   target_i,
  input  logic [2:0][31:0]   lo_i,
  input  logic [2:0][31:0]   hi_i,
  input  logic [2:0][31:0]   pos_i,
  output plan_t              plan_o,
  output logic [2:0][31:0]   delta_o
);

  logic [1:0]        n;
  logic [2:0][31:0]  tgt;
  logic [2:0][32:0]  diff;
  logic [2:0][31:0]  mag;

  always_comb begin
    n = (axis_count_i == 2'd0) ? 2'd1 : axis_count_i;
    plan_o = '0;
    for (int i = 0; i < 3; i++) begin
      plan_o.used[i] = (2'(i) < n);
      if ($signed(target_i[i]) < $signed(lo_i[i])) tgt[i] = lo_i[i];
      else if ($signed(target_i[i]) > $signed(hi_i[i])) tgt[i] = hi_i[i];
      else tgt[i] = target_i[i];
      diff[i] = {tgt[i][31], tgt[i]} - {pos_i[i][31], pos_i[i]};
      plan_o.backward[i] = diff[i][32];
      mag[i] = diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
      delta_o[i] = plan_o.used[i] ? mag[i] : 32'd0;
      if (plan_o.used[i] && (tgt[i] != pos_i[i])) plan_o.valid = 1'b1;
    end
    plan_o.lead = 2'd0;
    if (delta_o[1] > delta_o[0]) plan_o.lead = 2'd1;
    if (delta_o[2] > delta_o[plan_o.lead]) plan_o.lead = 2'd2;
  end

endmodule

/* src/scurve_stepper_interpolator_core.sv */
// scurve_stepper_interpolator_core: jerk-limited s-curve step generator, three axes
// depends on scsi_pkg and scsi_planner
//
// Usage: items come in on the in channel (valid/stall), one result per item
// leaves on the out channel. op selects tick, move, stop or set home. Each
// item is handled in one combinational pass into the result register, so
// its result shows in the cycle after it is taken, one item per cycle while
// not stalled; the profile accumulators and bresenham terms update in that pass.
// A new item is taken while a result waits, as long as the result register
// is empty or is being drained in the same cycle. When the receiver stalls,
// the result holds and in_stall_o rises so no item is lost.
// Configuration writes go through cfg_we_i/cfg_index_i/cfg_data_i, one a cycle,
// and are to be issued only while the block is idle.
// Reset clears all motion state, positions and the result register, and
// loads the default limits, axis count three and jerk 28.
module scurve_stepper_interpolator_core
  import scsi_pkg::*;
#(
  parameter int FRACTION_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [31:0]        target_x_i,
  input  logic [31:0]        target_y_i,
  input  logic [31:0]        target_z_i,
  input  logic [23:0]        ramp_ticks_i,
  input  logic [23:0]        cruise_accel_ticks_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               step_x_o,
  output logic               step_y_o,
  output logic               step_z_o,
  output logic               dir_x_o,
  output logic               dir_y_o,
  output logic               dir_z_o,
  output logic               moving_o,
  output logic [31:0]        pos_x_o,
  output logic [31:0]        pos_y_o,
  output logic [31:0]        pos_z_o
);

  localparam logic [63:0] FRAC_MASK = (64'd1 << FRACTION_BITS) - 64'd1;

  logic [1:0]        axis_count_q;
  logic [15:0]       jerk_q;
  logic [2:0][31:0]  lo_q, hi_q;

  logic              active_q, active_d;
  phase_e            phase_q, phase_d;
  logic [31:0]       pcnt_q, pcnt_d;
  logic [31:0]       done_q, done_d;
  logic [31:0]       total_q, total_d;
  logic [31:0]       flat_q, flat_d;
  logic [23:0]       ramp_q, ramp_d;
  logic [23:0]       cruise_q, cruise_d;
  logic [63:0]       acc_q, acc_d, spd_q, spd_d, dist_q, dist_d;
  logic [1:0]        lead_q, lead_d;
  logic [2:0][31:0]  pos_q, pos_d;
  logic [2:0][33:0]  err_q, err_d;
  logic [2:0][32:0]  dd_q, dd_d;
  logic [2:0]        back_q, back_d;

  logic              ov_q;
  logic [2:0]        step_q, step_d;
  logic              accept;

  plan_t             plan;
  logic [2:0][31:0]  delta;
  logic              carry, adv;
  logic [63:0]       dsum;
  logic [63:0]       j64;
  logic [32:0]       twice;
  logic [32:0]       fsum;
  logic [1:0]        n;
  logic [1:0]        m;

  assign in_stall_o = ov_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  scsi_planner u_plan (
    .axis_count_i (axis_count_q),
    .target_i     ({target_z_i, target_y_i, target_x_i}),
    .lo_i         (lo_q),
    .hi_i         (hi_q),
    .pos_i        (pos_q),
    .plan_o       (plan),
    .delta_o      (delta)
  );

  always_comb begin
    active_d = active_q; phase_d = phase_q; pcnt_d = pcnt_q; done_d = done_q;
    total_d = total_q; flat_d = flat_q; ramp_d = ramp_q; cruise_d = cruise_q;
    acc_d = acc_q; spd_d = spd_q; dist_d = dist_q; lead_d = lead_q;
    pos_d = pos_q; err_d = err_q; dd_d = dd_q; back_d = back_q;
    step_d = '0;
    j64 = {48'd0, jerk_q};
    adv = 1'b0;
    carry = 1'b0;
    dsum = '0;
    twice = '0;
    fsum = '0;
    n = (axis_count_q == 2'd0) ? 2'd1 : axis_count_q;
    m = (lead_q == 2'd3) ? 2'd0 : lead_q;
    unique case (op_e'(op_i))
      OP_TICK: begin
        if (active_q) begin
          case (phase_q)
            PH_JERK_UP, PH_JERK_DOWN, PH_DJERK_UP: begin
              if (pcnt_q < {8'd0, ramp_q}) begin
                if (phase_q == PH_JERK_UP) begin
                  acc_d = acc_q + j64; spd_d = spd_q + acc_d;
                end else if (phase_q == PH_JERK_DOWN) begin
                  acc_d = acc_q - j64; spd_d = spd_q + acc_d;
                end else begin
                  acc_d = acc_q + j64; spd_d = spd_q - acc_d;
                end
                adv = 1'b1;
                pcnt_d = pcnt_q + 32'd1;
              end
              if (pcnt_d >= {8'd0, ramp_q}) begin
                pcnt_d = '0;
                if (phase_q == PH_JERK_DOWN) begin
                  twice = {done_q, 1'b0};
                  if (twice < {1'b0, total_q}) begin
                    fsum = {1'b0, total_q} - twice + 33'd1;
                    flat_d = fsum[32] ? 32'hFFFF_FFFF : fsum[31:0];
                  end else begin
                    flat_d = 32'd1;
                  end
                end
                phase_d = phase_e'(phase_q + 3'd1);
              end
            end
            PH_ACCEL, PH_DECEL: begin
              if (pcnt_q < {8'd0, cruise_q}) begin
                spd_d = (phase_q == PH_ACCEL) ? spd_q + acc_q : spd_q - acc_q;
                adv = 1'b1;
                pcnt_d = pcnt_q + 32'd1;
              end
              if (pcnt_d >= {8'd0, cruise_q}) begin
                pcnt_d = '0;
                phase_d = phase_e'(phase_q + 3'd1);
              end
            end
            PH_CRUISE: begin
              adv = (pcnt_q < flat_q);
              if (pcnt_q < flat_q) begin
                dsum = dist_q + spd_q;
                if ((dsum & ~FRAC_MASK) != 64'd0) pcnt_d = pcnt_q + 32'd1;
              end
              if (pcnt_d >= flat_q) begin
                pcnt_d = '0;
                phase_d = PH_DJERK_UP;
              end
            end
            PH_TAIL: begin
              if (done_q < total_q) begin
                if ($signed(acc_q) > $signed({j64[62:0], 1'b0})) begin
                  acc_d = acc_q - j64; spd_d = spd_q - acc_d;
                end
                adv = 1'b1;
              end
            end
            default: ;
          endcase
          if (adv) begin
            dsum = dist_q + spd_d;
            carry = (dsum & ~FRAC_MASK) != 64'd0;
            dist_d = carry ? (dsum & FRAC_MASK) : dsum;
          end
          if (carry) begin
            for (int i = 0; i < 3; i++) begin
              if (2'(i) != m) begin
                if ($signed(err_q[i]) > 0) begin
                  err_d[i] = err_q[i] - {1'b0, dd_q[m]};
                  pos_d[i] = back_q[i] ? pos_q[i] - 32'd1 : pos_q[i] + 32'd1;
                  step_d[i] = 1'b1;
                end
                err_d[i] = err_d[i] + {1'b0, dd_q[i]};
              end
            end
            pos_d[m] = back_q[m] ? pos_q[m] - 32'd1 : pos_q[m] + 32'd1;
            step_d[m] = 1'b1;
            done_d = done_q + 32'd1;
            if (done_d == total_q) active_d = 1'b0;
          end
        end
      end
      OP_MOVE: begin
        if (!active_q && plan.valid) begin
          for (int i = 0; i < 3; i++) begin
            if (plan.used[i]) back_d[i] = plan.backward[i];
            dd_d[i] = {delta[i], 1'b0};
            err_d[i] = {1'b0, delta[i], 1'b0} - {2'b0, delta[plan.lead]};
          end
          lead_d = plan.lead;
          done_d = '0; total_d = delta[plan.lead];
          ramp_d = ramp_ticks_i; cruise_d = cruise_accel_ticks_i;
          flat_d = '0; pcnt_d = '0; phase_d = PH_JERK_UP;
          acc_d = '0; spd_d = '0; dist_d = '0;
          active_d = 1'b1;
        end
      end
      OP_STOP: active_d = 1'b0;
      OP_HOME: begin
        for (int i = 0; i < 3; i++) if (2'(i) < n) pos_d[i] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= 2'd3;
      jerk_q <= 16'd28;
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= 32'h8000_0000;
        hi_q[i] <= 32'h7FFF_FFFF;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_AXIS_COUNT: if (!active_q) axis_count_q <= cfg_data_i[1:0];
        REG_JERK:       if (!active_q) jerk_q <= cfg_data_i[15:0];
        REG_MIN_X:      lo_q[0] <= cfg_data_i;
        REG_MAX_X:      hi_q[0] <= cfg_data_i;
        REG_MIN_Y:      lo_q[1] <= cfg_data_i;
        REG_MAX_Y:      hi_q[1] <= cfg_data_i;
        REG_MIN_Z:      lo_q[2] <= cfg_data_i;
        REG_MAX_Z:      hi_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0; phase_q <= PH_JERK_UP; pcnt_q <= '0; done_q <= '0;
      total_q <= '0; flat_q <= '0; ramp_q <= '0; cruise_q <= '0;
      acc_q <= '0; spd_q <= '0; dist_q <= '0; lead_q <= '0;
      pos_q <= '0; err_q <= '0; dd_q <= '0; back_q <= '0;
      ov_q <= 1'b0; step_q <= '0;
    end else begin
      if (accept) begin
        active_q <= active_d; phase_q <= phase_d; pcnt_q <= pcnt_d; done_q <= done_d;
        total_q <= total_d; flat_q <= flat_d; ramp_q <= ramp_d; cruise_q <= cruise_d;
        acc_q <= acc_d; spd_q <= spd_d; dist_q <= dist_d; lead_q <= lead_d;
        pos_q <= pos_d; err_q <= err_d; dd_q <= dd_d; back_q <= back_d;
        step_q <= step_d;
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign step_x_o = step_q[0];
  assign step_y_o = step_q[1];
  assign step_z_o = step_q[2];
  assign dir_x_o  = back_q[0];
  assign dir_y_o  = back_q[1];
  assign dir_z_o  = back_q[2];
  assign moving_o = active_q;
  assign pos_x_o  = pos_q[0];
  assign pos_y_o  = pos_q[1];
  assign pos_z_o  = pos_q[2];

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");
  a_one_lead_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && (step_x_o || step_y_o || step_z_o))
      |-> (step_q[lead_q == 2'd3 ? 2'd0 : lead_q]))
    else $error("step without lead axis step");
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (done_q < total_q))
    else $error("move active past its step count");

endmodule

/* tb/sv/scsi_motion_checker.sv */
// scsi_motion_checker: watches the config port and both item channels of the
// s-curve step interpolator, predicts every result and compares it field by field
// depends on scsi_pkg
`timescale 1ns / 1ps
module scsi_motion_checker
  import scsi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] target_x_i,
  input  logic [31:0] target_y_i,
  input  logic [31:0] target_z_i,
  input  logic [23:0] ramp_ticks_i,
  input  logic [23:0] cruise_accel_ticks_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        step_x_i,
  input  logic        step_y_i,
  input  logic        step_z_i,
  input  logic        dir_x_i,
  input  logic        dir_y_i,
  input  logic        dir_z_i,
  input  logic        moving_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int FB = 48;
  localparam logic [63:0] FRAC_MASK = (64'd1 << FB) - 64'd1;

  typedef struct packed {
    logic [2:0]  step;
    logic [2:0]  dir;
    logic        moving;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } motion_t;

  logic [1:0]         axis_cfg;
  logic [15:0]        jerk_cfg;
  logic signed [31:0] lo_lim [3];
  logic signed [31:0] hi_lim [3];

  bit          running;
  phase_e      phase;
  logic [31:0] phase_cnt, steps_made, steps_goal, flat_goal;
  logic [23:0] ramp_len, cruise_len;
  logic [63:0] accel, speed, dist_acc;
  int          lead;
  logic [31:0] position [3];
  longint      berr [3];
  longint      bstep [3];
  bit          backward [3];

  motion_t expected_q[$];

  function automatic int axes_in_use();
    return (axis_cfg == 2'd0) ? 1 : int'(axis_cfg);
  endfunction

  function automatic bit add_distance();
    dist_acc = dist_acc + speed;
    if ((dist_acc & ~FRAC_MASK) != 64'd0) begin
      dist_acc = dist_acc & FRAC_MASK;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit profile_tick();
    logic [63:0] j, twice, f;
    bit carry;
    j = {48'd0, jerk_cfg};
    carry = 1'b0;
    case (phase)
      PH_JERK_UP, PH_JERK_DOWN, PH_DJERK_UP: begin
        if (phase_cnt < {8'd0, ramp_len}) begin
          if (phase == PH_JERK_UP) begin
            accel = accel + j;
            speed = speed + accel;
          end else if (phase == PH_JERK_DOWN) begin
            accel = accel - j;
            speed = speed + accel;
          end else begin
            accel = accel + j;
            speed = speed - accel;
          end
          carry = add_distance();
          phase_cnt = phase_cnt + 32'd1;
        end
        if (phase_cnt >= {8'd0, ramp_len}) begin
          phase_cnt = 32'd0;
          if (phase == PH_JERK_DOWN) begin
            twice = {32'd0, steps_made} << 1;
            if (twice < {32'd0, steps_goal}) begin
              f = {32'd0, steps_goal} - twice + 64'd1;
              flat_goal = (f > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : f[31:0];
            end else begin
              flat_goal = 32'd1;
            end
          end
          phase = phase_e'(phase + 3'd1);
        end
      end
      PH_ACCEL, PH_DECEL: begin
        if (phase_cnt < {8'd0, cruise_len}) begin
          if (phase == PH_ACCEL) speed = speed + accel;
          else speed = speed - accel;
          carry = add_distance();
          phase_cnt = phase_cnt + 32'd1;
        end
        if (phase_cnt >= {8'd0, cruise_len}) begin
          phase_cnt = 32'd0;
          phase = phase_e'(phase + 3'd1);
        end
      end
      PH_CRUISE: begin
        if (phase_cnt < flat_goal) begin
          carry = add_distance();
          if (carry) phase_cnt = phase_cnt + 32'd1;
        end
        if (phase_cnt >= flat_goal) begin
          phase_cnt = 32'd0;
          phase = PH_DJERK_UP;
        end
      end
      PH_TAIL: begin
        if (steps_made < steps_goal) begin
          if ($signed(accel) > $signed(j << 1)) begin
            accel = accel - j;
            speed = speed - accel;
          end
          carry = add_distance();
        end
      end
      default: ;
    endcase
    return carry;
  endfunction

  function automatic void begin_move(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                     logic [23:0] r, logic [23:0] c);
    longint tgt [3];
    longint delta [3];
    longint d;
    int n;
    bit any;
    n = axes_in_use();
    tgt[0] = longint'($signed(tx));
    tgt[1] = longint'($signed(ty));
    tgt[2] = longint'($signed(tz));
    any = 1'b0;
    for (int i = 0; i < 3; i++) delta[i] = 0;
    for (int i = 0; i < n; i++) begin
      if (tgt[i] < longint'(lo_lim[i])) tgt[i] = longint'(lo_lim[i]);
      else if (tgt[i] > longint'(hi_lim[i])) tgt[i] = longint'(hi_lim[i]);
      if (tgt[i] != longint'($signed(position[i]))) any = 1'b1;
    end
    if (!any) return;
    for (int i = 0; i < n; i++) begin
      d = tgt[i] - longint'($signed(position[i]));
      backward[i] = (d < 0);
      delta[i] = (d < 0) ? -d : d;
    end
    lead = 0;
    for (int i = 1; i < n; i++)
      if (delta[i] > delta[lead]) lead = i;
    for (int i = 0; i < 3; i++) begin
      bstep[i] = delta[i] * 2;
      berr[i] = bstep[i] - delta[lead];
    end
    steps_made = 32'd0;
    steps_goal = 32'(delta[lead]);
    ramp_len = r;
    cruise_len = c;
    flat_goal = 32'd0;
    phase_cnt = 32'd0;
    phase = PH_JERK_UP;
    accel = 64'd0;
    speed = 64'd0;
    dist_acc = 64'd0;
    running = 1'b1;
  endfunction

  function automatic motion_t predict_motion(op_e op, logic [31:0] tx, logic [31:0] ty,
                                             logic [31:0] tz, logic [23:0] r,
                                             logic [23:0] c);
    motion_t res;
    bit stepped [3];
    int m;
    for (int i = 0; i < 3; i++) stepped[i] = 1'b0;
    case (op)
      OP_TICK: begin
        if (running && profile_tick()) begin
          m = lead;
          for (int i = 0; i < 3; i++) begin
            if (i != m) begin
              if (berr[i] > 0) begin
                berr[i] = berr[i] - bstep[m];
                position[i] = position[i] + (backward[i] ? 32'hFFFF_FFFF : 32'd1);
                stepped[i] = 1'b1;
              end
              berr[i] = berr[i] + bstep[i];
            end
          end
          position[m] = position[m] + (backward[m] ? 32'hFFFF_FFFF : 32'd1);
          stepped[m] = 1'b1;
          steps_made = steps_made + 32'd1;
          if (steps_made == steps_goal) running = 1'b0;
        end
      end
      OP_MOVE: if (!running) begin_move(tx, ty, tz, r, c);
      OP_STOP: running = 1'b0;
      OP_HOME: for (int i = 0; i < axes_in_use(); i++) position[i] = 32'd0;
      default: ;
    endcase
    res.step = {stepped[2], stepped[1], stepped[0]};
    res.dir = {backward[2], backward[1], backward[0]};
    res.moving = running;
    res.px = position[0];
    res.py = position[1];
    res.pz = position[2];
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t want;
    if (!rst_ni) begin
      axis_cfg = 2'd3;
      jerk_cfg = 16'd28;
      for (int i = 0; i < 3; i++) begin
        lo_lim[i] = 32'sh8000_0000;
        hi_lim[i] = 32'sh7FFF_FFFF;
        position[i] = 32'd0;
        berr[i] = 0;
        bstep[i] = 0;
        backward[i] = 1'b0;
      end
      running = 1'b0;
      phase = PH_JERK_UP;
      phase_cnt = 32'd0;
      steps_made = 32'd0;
      steps_goal = 32'd0;
      flat_goal = 32'd0;
      ramp_len = 24'd0;
      cruise_len = 24'd0;
      accel = 64'd0;
      speed = 64'd0;
      dist_acc = 64'd0;
      lead = 0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_AXIS_COUNT: if (!running) axis_cfg = cfg_data_i[1:0];
          REG_JERK:       if (!running) jerk_cfg = cfg_data_i[15:0];
          REG_MIN_X:      lo_lim[0] = cfg_data_i;
          REG_MAX_X:      hi_lim[0] = cfg_data_i;
          REG_MIN_Y:      lo_lim[1] = cfg_data_i;
          REG_MAX_Y:      hi_lim[1] = cfg_data_i;
          REG_MIN_Z:      lo_lim[2] = cfg_data_i;
          REG_MAX_Z:      hi_lim[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("step_x", 32'(want.step[0]), 32'(step_x_i));
          check_field("step_y", 32'(want.step[1]), 32'(step_y_i));
          check_field("step_z", 32'(want.step[2]), 32'(step_z_i));
          check_field("dir_x", 32'(want.dir[0]), 32'(dir_x_i));
          check_field("dir_y", 32'(want.dir[1]), 32'(dir_y_i));
          check_field("dir_z", 32'(want.dir[2]), 32'(dir_z_i));
          check_field("moving", 32'(want.moving), 32'(moving_i));
          check_field("pos_x", want.px, pos_x_i);
          check_field("pos_y", want.py, pos_y_i);
          check_field("pos_z", want.pz, pos_z_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_motion(op_e'(op_i), target_x_i, target_y_i, target_z_i,
                                            ramp_ticks_i, cruise_accel_ticks_i));
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_scurve_stepper_interpolator_core.sv */
// tb_scurve_stepper_interpolator_core: stimulus, clock, reset and verdict for the
// s-curve step interpolator; prediction and compare live in scsi_motion_checker
// depends on scsi_pkg, scsi_motion_checker and scurve_stepper_interpolator_core
`timescale 1ns / 1ps
module tb_scurve_stepper_interpolator_core;
  import scsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [31:0] target_x_i, target_y_i, target_z_i;
  logic [23:0] ramp_ticks_i, cruise_accel_ticks_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        step_x_o, step_y_o, step_z_o;
  logic        dir_x_o, dir_y_o, dir_z_o;
  logic        moving_o;
  logic [31:0] pos_x_o, pos_y_o, pos_z_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_go = 1'b0;

  always #10 clk_i = ~clk_i;

  scurve_stepper_interpolator_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .target_x_i, .target_y_i, .target_z_i,
    .ramp_ticks_i, .cruise_accel_ticks_i, .out_valid_o, .out_stall_i,
    .step_x_o, .step_y_o, .step_z_o, .dir_x_o, .dir_y_o, .dir_z_o,
    .moving_o, .pos_x_o, .pos_y_o, .pos_z_o
  );

  scsi_motion_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .target_x_i, .target_y_i, .target_z_i,
    .ramp_ticks_i, .cruise_accel_ticks_i, .out_valid_i(out_valid_o), .out_stall_i,
    .step_x_i(step_x_o), .step_y_i(step_y_o), .step_z_i(step_z_o),
    .dir_x_i(dir_x_o), .dir_y_i(dir_y_o), .dir_z_i(dir_z_o), .moving_i(moving_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("** scurve_stepper_interpolator_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // result side: random stall bursts, one long hold on request
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] near_zero();
    logic [31:0] v;
    v = $urandom_range(1, 30);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_item(op_e op, logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                           logic [23:0] r, logic [23:0] c);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    target_x_i <= tx;
    target_y_i <= ty;
    target_z_i <= tz;
    ramp_ticks_i <= r;
    cruise_accel_ticks_i <= c;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [1:0] cnt, logic [15:0] j, logic [31:0] lx,
                              logic [31:0] hx, logic [31:0] ly, logic [31:0] hy,
                              logic [31:0] lz, logic [31:0] hz);
    settle();
    send_item(OP_STOP, $urandom(), $urandom(), $urandom(), 24'($urandom()),
              24'($urandom()));
    settle();
    put_reg(REG_AXIS_COUNT, {30'd0, cnt});
    put_reg(REG_JERK, {16'd0, j});
    put_reg(REG_MIN_X, lx);
    put_reg(REG_MAX_X, hx);
    put_reg(REG_MIN_Y, ly);
    put_reg(REG_MAX_Y, hy);
    put_reg(REG_MIN_Z, lz);
    put_reg(REG_MAX_Z, hz);
    cfg_we_i <= 1'b0;
  endtask

  // home, short move with long ramps, then a run of ticks and a stop
  task automatic long_move(int ticks, bit squeeze);
    send_item(OP_HOME, $urandom(), $urandom(), $urandom(), 24'($urandom()),
              24'($urandom()));
    send_item(OP_MOVE, near_zero(), near_zero(), near_zero(),
              24'($urandom_range(2000, 4000)), 24'($urandom_range(0, 2000)));
    for (int i = 0; i < ticks; i++) begin
      if (squeeze && i == ticks / 3) hold_go = 1'b1;
      send_item(OP_TICK, $urandom(), $urandom(), $urandom(), 24'($urandom()),
                24'($urandom()));
    end
    send_item(OP_STOP, $urandom(), $urandom(), $urandom(), 24'($urandom()),
              24'($urandom()));
  endtask

  task automatic mixed(int n);
    int k;
    logic [31:0] tx, ty, tz;
    logic [23:0] r, c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if ($urandom_range(0, 1)) begin
        tx = $urandom();
        ty = $urandom();
        tz = $urandom();
      end else begin
        tx = near_zero();
        ty = near_zero();
        tz = near_zero();
      end
      r = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(0, 20));
      c = $urandom_range(0, 1) ? 24'($urandom()) : 24'($urandom_range(0, 20));
      if (k < 5) send_item(OP_TICK, tx, ty, tz, r, c);
      else if (k < 8) send_item(OP_MOVE, tx, ty, tz, r, c);
      else if (k == 8) send_item(OP_STOP, tx, ty, tz, r, c);
      else send_item(OP_HOME, tx, ty, tz, r, c);
    end
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_AXIS_COUNT;
    cfg_data_i <= 32'd0;
    in_valid_i <= 1'b0;
    op_i <= OP_TICK;
    target_x_i <= 32'd0;
    target_y_i <= 32'd0;
    target_z_i <= 32'd0;
    ramp_ticks_i <= 24'd0;
    cruise_accel_ticks_i <= 24'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle corner cases, then moves to the field extremes mixed with ticks, home and stop
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_STOP, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_HOME, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_MOVE, 32'd0, 32'd0, 32'd0, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_MOVE, 32'd5, 32'd5, 32'd5, 24'd1, 24'd1);
    send_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_HOME, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_STOP, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);

    // jerk and axis count writes are dropped while a move is running
    settle();
    put_reg(REG_JERK, 32'd1);
    put_reg(REG_AXIS_COUNT, 32'd1);
    cfg_we_i <= 1'b0;
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);

    // narrow and reversed limits with zero ramps
    program_regs(2'd3, 16'hFFFF, -32'sd10, 32'sd10, 32'sd5, -32'sd5,
                 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_MOVE, 32'd100, 32'd0, -32'sd100, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_TICK, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);
    send_item(OP_STOP, 32'd0, 32'd0, 32'd0, 24'd0, 24'd0);

    program_regs(2'd1, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    long_move(20, 1'b0);
    mixed(75);

    program_regs(2'd0, 16'd1, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    mixed(75);

    program_regs(2'd2, 16'hFFFF, -32'sd1000, 32'sd1000, -32'sd1000, 32'sd1000,
                 -32'sd1000, 32'sd1000);
    long_move(20, 1'b1);
    mixed(75);

    program_regs(2'd3, 16'($urandom()), 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0,
                 $urandom(), $urandom());
    mixed(75);

    program_regs(2'd3, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    long_move(20, 1'b0);
    mixed(75);

    program_regs(2'd3, 16'd28, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
    mixed(40);
    calm = 1'b1;
    mixed(35);

    settle();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** scurve_stepper_interpolator_core: PASSED **");
    end else begin
      $display("** scurve_stepper_interpolator_core: FAILED **");
    end
    $finish;
  end

endmodule
